>>> rtl/u2da_pkg.sv
// ----------------------------------------------------------------------------
// u2da_pkg : shared types and constants for the decimal text converter
// Widths, digit types and the load record that passes from the converter
// to the digit emitter.
// ----------------------------------------------------------------------------
package u2da_pkg;

	localparam int NUM_BITS   = 16;
	localparam int NUM_DIGITS = 5;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 6;
	localparam int IDX_W      = $clog2(NUM_DIGITS);
	localparam int CNT_W      = $clog2(NUM_BITS);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

	typedef logic [DIGIT_W-1:0] digit_t;

	// hand-over from the cell row to the emitter
	typedef struct packed {
		logic             load;
		logic [IDX_W-1:0] top_idx;
	} emit_load_t;

endpackage

>>> rtl/u2da_dd_cell.sv
// ----------------------------------------------------------------------------
// u2da_dd_cell : one BCD digit cell of the shift-and-add-3 row
// Holds one decimal digit; on each shift it corrects the digit (add 3 when
// 5 or more), passes its top bit to the next cell and takes a bit from the
// previous one.
// ----------------------------------------------------------------------------
module u2da_dd_cell import u2da_pkg::*; (
	input  logic   clk,
	input  logic   clear,
	input  logic   shift,
	input  logic   bit_in,
	output logic   bit_out,
	output digit_t digit
);

	digit_t digit_q;
	digit_t adj;

	// add-3 correction before the shift
	always_comb begin
		adj = digit_q;
		if (digit_q >= DIGIT_W'(5)) begin
			adj = digit_q + DIGIT_W'(3);
		end
	end

	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	// digit register
	always_ff @(posedge clk) begin
		if (clear) begin
			digit_q <= '0;
		end else if (shift) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end
	end

endmodule

>>> rtl/u2da_emit.sv
// ----------------------------------------------------------------------------
// u2da_emit : digit emitter
// Holds a finished set of digits and sends them as ASCII, most significant
// first, one item per cycle while the output is not stalled, flagging the final digit.
// ----------------------------------------------------------------------------
module u2da_emit import u2da_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  emit_load_t                   ld,
	input  digit_t [NUM_DIGITS-1:0]      digits,
	output logic                         free,
	output logic                         valid,
	input  logic                         stall,
	output logic [CHAR_W-1:0]            digit_char,
	output logic                         last
);

	digit_t [NUM_DIGITS-1:0] digits_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    valid_q;

	assign free       = !valid_q;
	assign valid      = valid_q;
	assign last       = (idx_q == '0);
	assign digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_q[idx_q]};

	// control: index walks down from the top digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (ld.load) begin
			valid_q <= 1'b1;
			idx_q   <= ld.top_idx;
		end else if (valid_q && !stall) begin
			if (idx_q == '0) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	// digit store
	always_ff @(posedge clk) begin
		if (ld.load) begin
			digits_q <= digits;
		end
	end

endmodule

>>> rtl/u16_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// u16_to_decimal_ascii : 16-bit unsigned number to decimal ASCII digits
// A row of five BCD cells converts the number one bit per cycle; the
// emitter then sends the digits without leading zeros, final one flagged.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------
//   in       | in        | in_valid/in_stall  | number[15:0]
//   out      | out       | out_valid/out_stall| digit_char[5:0], last
//
// An item is shifted through the cell row one input bit per cycle, then
// handed over to the emitter, which sends 1 to 5 digits.
// Output of one item overlaps conversion of the next, so the input can
// take a new item while the emitter is still sending the last one.
// Reset clears all control; digit registers are cleared on each new item.
// A stalled output holds the emitter and, once the row is done, the input.
// ----------------------------------------------------------------------------
module u16_to_decimal_ascii import u2da_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [NUM_BITS-1:0] number,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CHAR_W-1:0]   digit_char,
	output logic                last
);

	logic [NUM_BITS-1:0]     num_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic                    in_acc;
	logic                    emit_free;
	logic                    xfer;
	logic [NUM_DIGITS:0]     chain;
	digit_t [NUM_DIGITS-1:0] digits;
	logic [IDX_W-1:0]        top_idx;
	emit_load_t              ld;

	assign in_stall = busy_q || done_q;
	assign in_acc   = in_valid && !in_stall;
	assign xfer     = done_q && emit_free;

	// converter control: bit counter and input shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(NUM_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (xfer) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			num_q <= number;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_BITS-2:0], 1'b0};
		end
	end

	// row of BCD cells, least significant digit first
	assign chain[0] = num_q[NUM_BITS-1];

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		u2da_dd_cell u_cell (
			.clk     (clk),
			.clear   (in_acc),
			.shift   (busy_q),
			.bit_in  (chain[i]),
			.bit_out (chain[i+1]),
			.digit   (digits[i])
		);
	end

	// highest non-zero digit; zero gives a single digit
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (digits[i] != '0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	assign ld.load    = xfer;
	assign ld.top_idx = top_idx;

	u2da_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.digits     (digits),
		.free       (emit_free),
		.valid      (out_valid),
		.stall      (out_stall),
		.digit_char (digit_char),
		.last       (last)
	);

	// checks
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_ZERO + CHAR_W'(9)))
		else $error("digit character out of range");

	a_busy_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q))
		else $error("converter busy and done together");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q && (cnt_q == '0))
		else $error("accepted item did not start conversion");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |-> !out_valid)
		else $error("emitter loaded while still sending");

	a_row_no_carry: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !chain[NUM_DIGITS])
		else $error("carry out of the top digit cell");

endmodule
